// File: sv/projective_warp_address_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the projective warp address block
// Implication checks sampled on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PROJECTIVE_WARP_ADDRESS_ASSERT_SVH
`define PROJECTIVE_WARP_ADDRESS_ASSERT_SVH

// same-cycle implication
`define PWA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pwa assertion failed");

// next-cycle implication
`define PWA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pwa assertion failed");

`endif

// File: sv/pwa_pkg.sv
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared widths, register indexes and types of the projective warp address.
// ----------------------------------------------------------------------------
package pwa_pkg;
  localparam int CoefW   = 48;
  localparam int FieldW  = 11;
  localparam int IdxW    = 4;
  localparam int ProdW   = CoefW + FieldW + 1;
  localparam int NumW    = ProdW + 2;
  localparam int XW      = NumW + FieldW;
  localparam int FifoDepth = 4;
  localparam int SrcRowsDef = 512;
  localparam int SrcColsDef = 512;
  localparam logic [CoefW-1:0] OneQ24 = CoefW'(64'd16777216);

  localparam logic [IdxW-1:0] RegURow = 4'd0;
  localparam logic [IdxW-1:0] RegUCol = 4'd1;
  localparam logic [IdxW-1:0] RegUOff = 4'd2;
  localparam logic [IdxW-1:0] RegVRow = 4'd3;
  localparam logic [IdxW-1:0] RegVCol = 4'd4;
  localparam logic [IdxW-1:0] RegVOff = 4'd5;
  localparam logic [IdxW-1:0] RegWRow = 4'd6;
  localparam logic [IdxW-1:0] RegWCol = 4'd7;

  typedef struct packed {
    logic signed [CoefW-1:0] u_row_gain;
    logic signed [CoefW-1:0] u_col_gain;
    logic signed [CoefW-1:0] u_offset;
    logic signed [CoefW-1:0] v_row_gain;
    logic signed [CoefW-1:0] v_col_gain;
    logic signed [CoefW-1:0] v_offset;
    logic signed [CoefW-1:0] w_row_gain;
    logic signed [CoefW-1:0] w_col_gain;
  } pwa_coef_t;

  typedef struct packed {
    logic signed [NumW-1:0] u;
    logic signed [NumW-1:0] v;
    logic signed [NumW-1:0] w;
  } pwa_num_t;
endpackage

// File: sv/pwa_front.sv
// ----------------------------------------------------------------------------
// pwa_front
// Accepts destination positions and forms numerators and denominator.
// ----------------------------------------------------------------------------
module pwa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pwa_pkg::pwa_coef_t       coef_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [pwa_pkg::FieldW-1:0] dst_row_i,
  input  logic [pwa_pkg::FieldW-1:0] dst_col_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pwa_pkg::pwa_num_t        out_num_o
);
  import pwa_pkg::*;

  logic v1_q, v2_q, adv1, adv2;
  logic signed [ProdW-1:0] pur_q, puc_q, pvr_q, pvc_q, pwr_q, pwc_q;
  logic signed [FieldW:0]  r_s, c_s;
  pwa_num_t num_q;

  assign adv2 = !v2_q || out_ready_i;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign out_valid_o = v2_q;
  assign out_num_o = num_q;
  assign r_s = $signed({1'b0, dst_row_i});
  assign c_s = $signed({1'b0, dst_col_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      pur_q <= ProdW'(coef_i.u_row_gain * r_s);
      puc_q <= ProdW'(coef_i.u_col_gain * c_s);
      pvr_q <= ProdW'(coef_i.v_row_gain * r_s);
      pvc_q <= ProdW'(coef_i.v_col_gain * c_s);
      pwr_q <= ProdW'(coef_i.w_row_gain * r_s);
      pwc_q <= ProdW'(coef_i.w_col_gain * c_s);
    end
    if (adv2) begin
      num_q.u <= NumW'(pur_q) + NumW'(puc_q) + NumW'(coef_i.u_offset);
      num_q.v <= NumW'(pvr_q) + NumW'(pvc_q) + NumW'(coef_i.v_offset);
      num_q.w <= NumW'(pwr_q) + NumW'(pwc_q) + NumW'($signed(OneQ24));
    end
  end
endmodule

// File: sv/pwa_fifo.sv
// ----------------------------------------------------------------------------
// pwa_fifo
// Short queue between the front and back sections.
// ----------------------------------------------------------------------------
module pwa_fifo #(
  parameter int Width = 8,
  parameter int Depth = pwa_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == CW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop) rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end
endmodule

// File: sv/pwa_back.sv
// ----------------------------------------------------------------------------
// pwa_back
// Pipelined truncating divide of both numerators, range check, result word.
// ----------------------------------------------------------------------------
module pwa_back #(
  parameter int SrcRows = pwa_pkg::SrcRowsDef,
  parameter int SrcCols = pwa_pkg::SrcColsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pwa_pkg::pwa_num_t          in_num_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pwa_pkg::FieldW-1:0] src_row_o,
  output logic [pwa_pkg::FieldW-1:0] src_col_o,
  output logic                       in_range_o
);
  import pwa_pkg::*;
  localparam int NIt = FieldW;

  logic en;
  logic va_q;
  logic [NumW-1:0] mnu_a_q, mnv_a_q, md_a_q;
  logic negu_a_q, negv_a_q;

  logic            vld_q  [NIt+1];
  logic [NumW-1:0] remu_q [NIt+1];
  logic [NumW-1:0] remv_q [NIt+1];
  logic [NumW-1:0] md_q   [NIt+1];
  logic [FieldW-1:0] qu_q [NIt+1];
  logic [FieldW-1:0] qv_q [NIt+1];
  logic negu_q [NIt+1];
  logic negv_q [NIt+1];
  logic bad_q  [NIt+1];

  logic vo_q, ok_q;
  logic [FieldW-1:0] ro_q, co_q;
  logic [XW-1:0] lim;
  logic ok_d;

  assign en = !vo_q || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vo_q;
  assign src_row_o = ro_q;
  assign src_col_o = co_q;
  assign in_range_o = ok_q;
  assign lim = {{FieldW{1'b0}}, md_a_q} << FieldW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      for (int k = 0; k <= NIt; k++) vld_q[k] <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vld_q[0] <= va_q;
      for (int k = 0; k < NIt; k++) vld_q[k+1] <= vld_q[k];
      vo_q <= vld_q[NIt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mnu_a_q  <= in_num_i.u[NumW-1] ? NumW'(-in_num_i.u) : in_num_i.u;
      mnv_a_q  <= in_num_i.v[NumW-1] ? NumW'(-in_num_i.v) : in_num_i.v;
      md_a_q   <= in_num_i.w[NumW-1] ? NumW'(-in_num_i.w) : in_num_i.w;
      negu_a_q <= in_num_i.u[NumW-1] != in_num_i.w[NumW-1];
      negv_a_q <= in_num_i.v[NumW-1] != in_num_i.w[NumW-1];

      remu_q[0] <= mnu_a_q;
      remv_q[0] <= mnv_a_q;
      md_q[0]   <= md_a_q;
      qu_q[0]   <= '0;
      qv_q[0]   <= '0;
      negu_q[0] <= negu_a_q;
      negv_q[0] <= negv_a_q;
      bad_q[0]  <= (md_a_q == '0) || (XW'(mnu_a_q) >= lim) || (XW'(mnv_a_q) >= lim);

      ro_q <= ok_d ? qu_q[NIt] : '0;
      co_q <= ok_d ? qv_q[NIt] : '0;
      ok_q <= ok_d;
    end
  end

  for (genvar k = 0; k < NIt; k++) begin : g_it
    localparam int B = NIt - 1 - k;
    logic [XW-1:0] sh;
    logic geu, gev;
    assign sh  = {{FieldW{1'b0}}, md_q[k]} << B;
    assign geu = XW'(remu_q[k]) >= sh;
    assign gev = XW'(remv_q[k]) >= sh;
    always_ff @(posedge clk_i) begin
      if (en) begin
        remu_q[k+1] <= geu ? NumW'(XW'(remu_q[k]) - sh) : remu_q[k];
        remv_q[k+1] <= gev ? NumW'(XW'(remv_q[k]) - sh) : remv_q[k];
        qu_q[k+1]   <= qu_q[k] | (FieldW'(geu) << B);
        qv_q[k+1]   <= qv_q[k] | (FieldW'(gev) << B);
        md_q[k+1]   <= md_q[k];
        negu_q[k+1] <= negu_q[k];
        negv_q[k+1] <= negv_q[k];
        bad_q[k+1]  <= bad_q[k];
      end
    end
  end

  always_comb begin
    ok_d = !bad_q[NIt]
        && (!negu_q[NIt] || qu_q[NIt] == '0)
        && (!negv_q[NIt] || qv_q[NIt] == '0)
        && ({1'b0, qu_q[NIt]} < (FieldW+1)'(SrcRows))
        && ({1'b0, qv_q[NIt]} < (FieldW+1)'(SrcCols));
  end
endmodule

// File: sv/projective_warp_address.sv
// ----------------------------------------------------------------------------
// projective_warp_address
// Maps destination pixel positions to source positions by a homography.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tdata: dst_row[10:0], dst_col[21:11]
// m_axis   out  tdata: src_row[10:0], src_col[21:11]; tuser: in_range
// cfg      in   index 0..7 selects the coefficient, data 48-bit Q23.24
// One word per cycle while the output accepts; 2 front stages, queue, 14 back stages.
// The back section runs an 11-stage restoring divide, one quotient bit a stage.
// Reset restores identity coefficients; no clearing pass.
// A stalled output freezes the back section; the 4-entry queue decouples the front.
module projective_warp_address #(
  parameter int SRC_ROWS = pwa_pkg::SrcRowsDef,
  parameter int SRC_COLS = pwa_pkg::SrcColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pwa_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [pwa_pkg::CoefW-1:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // dst_row, dst_col, zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // src_row, src_col, zero pad
  output logic        m_axis_tuser_o    // in_range
);
  import pwa_pkg::*;
  `include "projective_warp_address_assert.svh"

  pwa_coef_t coef_q;
  pwa_num_t  f_num, q_num;
  logic f_valid, q_full, q_empty, b_ready;
  logic [FieldW-1:0] src_row, src_col;
  logic [$bits(pwa_num_t)-1:0] q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{u_row_gain: OneQ24, v_col_gain: OneQ24, default: '0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegURow: coef_q.u_row_gain <= cfg_data_i;
        RegUCol: coef_q.u_col_gain <= cfg_data_i;
        RegUOff: coef_q.u_offset   <= cfg_data_i;
        RegVRow: coef_q.v_row_gain <= cfg_data_i;
        RegVCol: coef_q.v_col_gain <= cfg_data_i;
        RegVOff: coef_q.v_offset   <= cfg_data_i;
        RegWRow: coef_q.w_row_gain <= cfg_data_i;
        RegWCol: coef_q.w_col_gain <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pwa_front u_front (
    .clk_i, .rst_ni,
    .coef_i      (coef_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .dst_row_i   (s_axis_tdata_i[10:0]),
    .dst_col_i   (s_axis_tdata_i[21:11]),
    .out_valid_o (f_valid),
    .out_ready_i (!q_full),
    .out_num_o   (f_num)
  );

  pwa_fifo #(.Width($bits(pwa_num_t)), .Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (f_valid),
    .data_i  (f_num),
    .full_o  (q_full),
    .pop_i   (b_ready),
    .empty_o (q_empty),
    .data_o  (q_data)
  );
  assign q_num = q_data;

  pwa_back #(.SrcRows(SRC_ROWS), .SrcCols(SRC_COLS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i  (!q_empty),
    .in_ready_o  (b_ready),
    .in_num_i    (q_num),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .src_row_o   (src_row),
    .src_col_o   (src_col),
    .in_range_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, src_col, src_row};

  `PWA_ASSERT_NOW(a_row_lim, m_axis_tvalid_o && m_axis_tuser_o,
                  {1'b0, src_row} < (FieldW+1)'(SRC_ROWS))
  `PWA_ASSERT_NOW(a_col_lim, m_axis_tvalid_o && m_axis_tuser_o,
                  {1'b0, src_col} < (FieldW+1)'(SRC_COLS))
  `PWA_ASSERT_NOW(a_zero_out, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0)
  `PWA_ASSERT_NXT(a_hold_back, m_axis_tvalid_o && !m_axis_tready_i && !q_empty, !q_empty)
endmodule
